// ===== rtl/core/tbp_pkg.sv =====
`default_nettype none
package tbp_pkg;

	// Default history and index sizes.
	localparam int unsigned MAX_GLOBAL_BITS_DEF = 12;
	localparam int unsigned MAX_LOCAL_BITS_DEF  = 12;
	localparam int unsigned MAX_PC_BITS_DEF     = 12;

	// Configuration port geometry.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 4;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_GLOBAL_BITS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_BITS  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PC_BITS     = 2'd2;

	// Configuration reset values.
	localparam logic [CFG_DATA_W-1:0] GLOBAL_BITS_RST = 4'd9;
	localparam logic [CFG_DATA_W-1:0] LOCAL_BITS_RST  = 4'd10;
	localparam logic [CFG_DATA_W-1:0] PC_BITS_RST     = 4'd10;

	// Request kinds.
	localparam logic REQ_PREDICT = 1'b0;
	localparam logic REQ_TRAIN   = 1'b1;

	// Counter reset value: weakly not taken.
	localparam logic [1:0] CTR_INIT = 2'd1;

	// Stream widths.
	localparam int unsigned PC_W       = 32;
	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 8;
	localparam int unsigned MASK_W      = 16;

	// Index masks derived from the configuration registers.
	typedef struct packed {
		logic [MASK_W-1:0] gmask;
		logic [MASK_W-1:0] lmask;
		logic [MASK_W-1:0] pmask;
	} masks_t;

	// Sequencer status seen by the top level.
	typedef struct packed {
		logic clearing;
		logic busy;
	} status_t;

	// Clamp a size to 1..maxbits and turn it into a low-bit mask.
	function automatic logic [MASK_W-1:0] size_mask(input logic [CFG_DATA_W-1:0] bits,
	                                                input int unsigned maxbits);
		logic [4:0]        b;
		logic [MASK_W:0]   m;
		b = {1'b0, bits};
		if (b == 5'd0) begin
			b = 5'd1;
		end
		if (b > 5'(maxbits)) begin
			b = 5'(maxbits);
		end
		m = (17'd1 << b) - 17'd1;
		return m[MASK_W-1:0];
	endfunction

	// Two-bit saturating counter step.
	function automatic logic [1:0] bump(input logic [1:0] ctr, input logic up);
		logic [1:0] r;
		r = ctr;
		if (up) begin
			if (ctr != 2'd3) begin
				r = ctr + 2'd1;
			end
		end else begin
			if (ctr != 2'd0) begin
				r = ctr - 2'd1;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tbp_ram.sv =====
`default_nettype none
module tbp_ram #(
	parameter int unsigned W  = 2,
	parameter int unsigned AW = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [2**AW];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/tbp_core.sv =====
`default_nettype none
module tbp_core #(
	parameter int unsigned MAX_GLOBAL_BITS = tbp_pkg::MAX_GLOBAL_BITS_DEF,
	parameter int unsigned MAX_LOCAL_BITS  = tbp_pkg::MAX_LOCAL_BITS_DEF,
	parameter int unsigned MAX_PC_BITS     = tbp_pkg::MAX_PC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire tbp_pkg::masks_t            masks,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       in_train,
	input  wire logic [tbp_pkg::PC_W-1:0]   in_pc,
	input  wire logic                       in_taken,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            out_taken,
	output tbp_pkg::status_t                status
);

	localparam int unsigned GW = MAX_GLOBAL_BITS;
	localparam int unsigned LW = MAX_LOCAL_BITS;
	localparam int unsigned PW = MAX_PC_BITS;
	localparam int unsigned GL_MAX   = (GW > LW) ? GW : LW;
	localparam int unsigned CLR_BITS = (GL_MAX > PW) ? GL_MAX : PW;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LHT,
		ST_LC
	} state_t;

	state_t               state_q;
	logic [CLR_BITS-1:0]  clr_q;
	logic                 train_s1;
	logic                 taken_s1;
	logic [PW-1:0]        pidx_s1;
	logic [GW-1:0]        gidx_s1;
	logic [LW-1:0]        lidx_s2;
	logic [GW-1:0]        ghist_q;
	logic                 last_local_q;
	logic                 last_global_q;
	logic                 out_valid_q;
	logic                 out_taken_q;

	logic [GW-1:0]        gmask;
	logic [LW-1:0]        lmask;
	logic [PW-1:0]        pmask;
	logic                 accept;
	logic [PW-1:0]        pidx_in;
	logic [GW-1:0]        gidx_in;
	logic [LW-1:0]        lidx_rd;
	logic                 finish;
	logic                 clearing;
	logic                 do_train;

	logic                 lht_we;
	logic [PW-1:0]        lht_waddr;
	logic [LW-1:0]        lht_wdata;
	logic [PW-1:0]        lht_raddr;
	logic [LW-1:0]        lht_rdata;
	logic                 lc_we;
	logic [LW-1:0]        lc_waddr;
	logic [1:0]           lc_wdata;
	logic [LW-1:0]        lc_raddr;
	logic [1:0]           lc_rdata;
	logic                 gc_we;
	logic [GW-1:0]        gc_waddr;
	logic [3:0]           gc_wdata;
	logic [GW-1:0]        gc_raddr;
	logic [3:0]           gc_rdata;

	logic [1:0]           chooser;
	logic [1:0]           gctr;
	logic                 local_guess;
	logic                 global_guess;
	logic [1:0]           chooser_nx;
	logic [GW-1:0]        ghist_nx;

	assign gmask = masks.gmask[GW-1:0];
	assign lmask = masks.lmask[LW-1:0];
	assign pmask = masks.pmask[PW-1:0];

	assign clearing = (state_q == ST_CLEAR);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign pidx_in  = in_pc[PW-1:0] & pmask;
	assign gidx_in  = ghist_q & gmask;
	assign lidx_rd  = lht_rdata & lmask;

	// Counter readout and guesses in the last stage.
	assign chooser      = gc_rdata[3:2];
	assign gctr         = gc_rdata[1:0];
	assign local_guess  = lc_rdata[1];
	assign global_guess = gctr[1];

	// A predict waits here only while the output register still holds a result.
	assign finish   = (state_q == ST_LC) && (train_s1 || !out_valid_q || out_ready);
	assign do_train = (state_q == ST_LC) && train_s1;

	// Chooser moves toward the guess that alone was right.
	always_comb begin
		chooser_nx = chooser;
		if (last_local_q != taken_s1 && last_global_q == taken_s1) begin
			chooser_nx = tbp_pkg::bump(chooser, 1'b0);
		end else if (last_local_q == taken_s1 && last_global_q != taken_s1) begin
			chooser_nx = tbp_pkg::bump(chooser, 1'b1);
		end
	end

	assign ghist_nx = ((gidx_s1 << 1) | GW'(taken_s1)) & gmask;

	// Read addresses stay on the item's indexes so read data holds.
	always_comb begin
		lht_raddr = (state_q == ST_IDLE) ? pidx_in : pidx_s1;
		gc_raddr  = (state_q == ST_IDLE) ? gidx_in : gidx_s1;
		lc_raddr  = (state_q == ST_LHT) ? lidx_rd : lidx_s2;
	end

	// Write ports: reset sweep, or the train write-back.
	always_comb begin
		if (clearing) begin
			lht_we    = 1'b1;
			lht_waddr = clr_q[PW-1:0];
			lht_wdata = '0;
			lc_we     = 1'b1;
			lc_waddr  = clr_q[LW-1:0];
			lc_wdata  = tbp_pkg::CTR_INIT;
			gc_we     = 1'b1;
			gc_waddr  = clr_q[GW-1:0];
			gc_wdata  = {tbp_pkg::CTR_INIT, tbp_pkg::CTR_INIT};
		end else begin
			lht_we    = do_train;
			lht_waddr = pidx_s1;
			lht_wdata = ((lidx_s2 << 1) | LW'(taken_s1)) & lmask;
			lc_we     = do_train;
			lc_waddr  = lidx_s2;
			lc_wdata  = tbp_pkg::bump(lc_rdata, taken_s1);
			gc_we     = do_train;
			gc_waddr  = gidx_s1;
			gc_wdata  = {chooser_nx, tbp_pkg::bump(gctr, taken_s1)};
		end
	end

	tbp_ram #(.W(LW), .AW(PW)) u_lht (
		.clk   (clk),
		.we    (lht_we),
		.waddr (lht_waddr),
		.wdata (lht_wdata),
		.raddr (lht_raddr),
		.rdata (lht_rdata)
	);

	tbp_ram #(.W(2), .AW(LW)) u_lc (
		.clk   (clk),
		.we    (lc_we),
		.waddr (lc_waddr),
		.wdata (lc_wdata),
		.raddr (lc_raddr),
		.rdata (lc_rdata)
	);

	tbp_ram #(.W(4), .AW(GW)) u_gc (
		.clk   (clk),
		.we    (gc_we),
		.waddr (gc_waddr),
		.wdata (gc_wdata),
		.raddr (gc_raddr),
		.rdata (gc_rdata)
	);

	// Sequencer, item registers, histories and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			train_s1      <= 1'b0;
			taken_s1      <= 1'b0;
			pidx_s1       <= '0;
			gidx_s1       <= '0;
			lidx_s2       <= '0;
			ghist_q       <= '0;
			last_local_q  <= 1'b0;
			last_global_q <= 1'b0;
			out_valid_q   <= 1'b0;
			out_taken_q   <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						train_s1 <= in_train;
						taken_s1 <= in_taken;
						pidx_s1  <= pidx_in;
						gidx_s1  <= gidx_in;
						state_q  <= ST_LHT;
					end
				end
				ST_LHT: begin
					lidx_s2 <= lidx_rd;
					state_q <= ST_LC;
				end
				ST_LC: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (train_s1) begin
							ghist_q <= ghist_nx;
						end else begin
							last_local_q  <= local_guess;
							last_global_q <= global_guess;
							out_valid_q   <= 1'b1;
							out_taken_q   <= chooser[1] ? local_guess : global_guess;
						end
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign out_taken       = out_taken_q;
	assign status.clearing = clearing;
	assign status.busy     = (state_q == ST_LHT) || (state_q == ST_LC);

endmodule
`default_nettype wire

// ===== rtl/core/tournament_branch_predictor_top.sv =====
// Tournament branch predictor with local, global and chooser counters.
// Input stream: s_axis_tuser is the request kind (predict or train);
// s_axis_tdata carries the branch PC and, for train, the actual outcome.
// Output stream: one item per predict request, bit 0 of m_axis_tdata is the
// taken guess. Train requests give no output item.
// Each request passes the local history table read and then the dependent
// local counter read, each one synchronous memory read, and a last step that
// forms the guess or writes all tables back. A new request is taken only
// once the previous one has finished.
// After reset the block sweeps its tables to their initial values and holds
// s_axis_tready low over all 2**max(MAX_*_BITS) addresses (4096 with the defaults).
// Configuration writes are taken at any time and should be made while idle.
// A finished guess waits in the output register; the block still accepts a
// request meanwhile and only holds a later predict in its last cycle until
// the receiver takes the pending one.
`default_nettype none
module tournament_branch_predictor_top #(
	parameter int unsigned MAX_GLOBAL_BITS = tbp_pkg::MAX_GLOBAL_BITS_DEF,
	parameter int unsigned MAX_LOCAL_BITS  = tbp_pkg::MAX_LOCAL_BITS_DEF,
	parameter int unsigned MAX_PC_BITS     = tbp_pkg::MAX_PC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [tbp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [tbp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// Fields from bit 0: pc[31:0], outcome[32], zero fill [39:33].
	input  wire logic [tbp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// Fields from bit 0: req_type[0].
	input  wire logic                                s_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// Fields from bit 0: taken_guess[0], zero fill [7:1].
	output logic [tbp_pkg::OUT_TDATA_W-1:0]          m_axis_tdata
);

	logic [tbp_pkg::CFG_DATA_W-1:0] ghb_q;
	logic [tbp_pkg::CFG_DATA_W-1:0] lhb_q;
	logic [tbp_pkg::CFG_DATA_W-1:0] pcb_q;
	tbp_pkg::masks_t                masks;
	tbp_pkg::status_t               status;
	logic                           taken_guess;

	// Configuration registers; an unknown index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ghb_q <= tbp_pkg::GLOBAL_BITS_RST;
			lhb_q <= tbp_pkg::LOCAL_BITS_RST;
			pcb_q <= tbp_pkg::PC_BITS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tbp_pkg::CFG_GLOBAL_BITS: ghb_q <= cfg_wdata;
				tbp_pkg::CFG_LOCAL_BITS:  lhb_q <= cfg_wdata;
				tbp_pkg::CFG_PC_BITS:     pcb_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Sizes clamp to 1..maximum before they become index masks.
	assign masks.gmask = tbp_pkg::size_mask(ghb_q, MAX_GLOBAL_BITS);
	assign masks.lmask = tbp_pkg::size_mask(lhb_q, MAX_LOCAL_BITS);
	assign masks.pmask = tbp_pkg::size_mask(pcb_q, MAX_PC_BITS);

	tbp_core #(
		.MAX_GLOBAL_BITS (MAX_GLOBAL_BITS),
		.MAX_LOCAL_BITS  (MAX_LOCAL_BITS),
		.MAX_PC_BITS     (MAX_PC_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.masks     (masks),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_train  (s_axis_tuser == tbp_pkg::REQ_TRAIN),
		.in_pc     (s_axis_tdata[tbp_pkg::PC_W-1:0]),
		.in_taken  (s_axis_tdata[tbp_pkg::PC_W]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_taken (taken_guess),
		.status    (status)
	);

	assign m_axis_tdata = {{(tbp_pkg::OUT_TDATA_W-1){1'b0}}, taken_guess};

	// No request is taken while the tables are being swept.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> !s_axis_tready)
		else $error("request accepted during table sweep");

	// An accepted request occupies the sequencer in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (status.busy && !s_axis_tready))
		else $error("sequencer not busy after request");

	// A fresh output item comes only from an accepted predict request.
	a_out_from_predict: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |->
			$past(s_axis_tvalid && s_axis_tready &&
			      (s_axis_tuser == tbp_pkg::REQ_PREDICT), 3))
		else $error("output item without a matching predict request");

endmodule
`default_nettype wire

// ===== test/tournament_branch_predictor_top_tb.sv =====
`default_nettype none
module tournament_branch_predictor_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Index that maps to no register; a write there must change nothing.
	localparam logic [tbp_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int unsigned TABLE_DEPTH = 4096;
	localparam int PHASES = 7;
	localparam int ITEMS_PER_PHASE = 264;
	localparam int DIRECTED_ROWS = 23;

	typedef struct packed {
		logic        req_type;
		logic [31:0] pc;
		logic        outcome;
	} branch_req_t;

	typedef struct packed {
		branch_req_t req;
		logic        typed;
		logic        guess;
	} directed_row_t;

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [tbp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [tbp_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [tbp_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                            s_axis_tuser = 1'b0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [tbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	tournament_branch_predictor_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Predictor state and its copy of the size registers.
	logic [11:0] local_hist [TABLE_DEPTH];
	logic [1:0]  local_ctr [TABLE_DEPTH];
	logic [1:0]  global_ctr [TABLE_DEPTH];
	logic [1:0]  chooser_ctr [TABLE_DEPTH];
	logic [11:0] global_hist;
	logic        kept_local;
	logic        kept_global;
	logic [3:0]  gbits;
	logic [3:0]  lbits;
	logic [3:0]  pbits;

	logic pending_guesses [$];
	int   errors = 0;
	int   send_idle = 0;
	int   recv_idle = 0;

	// Size settings per random phase: global, local, PC index bits.
	logic [3:0] phase_cfg [PHASES][3] = '{
		'{4'd1, 4'd1, 4'd1},
		'{4'd12, 4'd12, 4'd12},
		'{4'd0, 4'd0, 4'd0},
		'{4'd15, 4'd15, 4'd15},
		'{4'd4, 4'd11, 4'd3},
		'{4'd0, 4'd0, 4'd0},
		'{4'd9, 4'd10, 4'd10}
	};

	// Directed stimulus: reset state, PC extremes, aliasing and saturation.
	directed_row_t directed [DIRECTED_ROWS] = '{
		'{'{tbp_pkg::REQ_TRAIN, 32'hFFFF_FFFF, 1'b0}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_PREDICT, 32'h0000_0000, 1'b0}, 1'b1, 1'b0},
		'{'{tbp_pkg::REQ_PREDICT, 32'hFFFF_FFFF, 1'b1}, 1'b1, 1'b0},
		'{'{tbp_pkg::REQ_PREDICT, 32'h8000_0004, 1'b0}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_TRAIN, 32'h8000_0004, 1'b1}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_PREDICT, 32'h8000_0004, 1'b0}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_TRAIN, 32'h8000_0004, 1'b1}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_PREDICT, 32'h8000_0004, 1'b1}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_TRAIN, 32'h8000_0004, 1'b1}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_PREDICT, 32'h8000_0004, 1'b0}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_TRAIN, 32'h8000_0004, 1'b1}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_PREDICT, 32'h7FFF_FFFB, 1'b0}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_TRAIN, 32'h7FFF_FFFB, 1'b0}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_PREDICT, 32'h7FFF_FFFB, 1'b1}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_TRAIN, 32'h7FFF_FFFB, 1'b0}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_PREDICT, 32'h0000_0400, 1'b0}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_TRAIN, 32'h0000_0400, 1'b1}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_PREDICT, 32'hAAAA_AAAA, 1'b0}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_TRAIN, 32'hAAAA_AAAA, 1'b0}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_PREDICT, 32'h5555_5555, 1'b1}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_TRAIN, 32'h5555_5555, 1'b1}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_TRAIN, 32'h5555_5555, 1'b1}, 1'b0, 1'b0},
		'{'{tbp_pkg::REQ_PREDICT, 32'h5555_5555, 1'b0}, 1'b0, 1'b0}
	};

	// Clamp a size register to 1..limit and return the matching low-bit mask.
	function automatic logic [11:0] field_mask(input logic [3:0] bits, input int unsigned limit);
		int unsigned b;
		b = (bits == 4'd0) ? 1 : int'(bits);
		if (b > limit) begin
			b = limit;
		end
		return 12'((32'd1 << b) - 32'd1);
	endfunction

	// Two-bit saturating counter moved one step up or down.
	function automatic logic [1:0] sat_step(input logic [1:0] ctr, input logic up);
		if (up) begin
			return (ctr == 2'd3) ? ctr : ctr + 2'd1;
		end
		return (ctr == 2'd0) ? ctr : ctr - 2'd1;
	endfunction

	// Apply one request to the predictor state; returns 1 when a guess is produced.
	function automatic bit run_tournament(input branch_req_t r, output logic guess);
		logic [11:0] lmask;
		logic [11:0] gmask;
		logic [11:0] pidx;
		logic [11:0] lidx;
		logic [11:0] gidx;
		lmask = field_mask(lbits, tbp_pkg::MAX_LOCAL_BITS_DEF);
		gmask = field_mask(gbits, tbp_pkg::MAX_GLOBAL_BITS_DEF);
		pidx = r.pc[11:0] & field_mask(pbits, tbp_pkg::MAX_PC_BITS_DEF);
		lidx = local_hist[pidx] & lmask;
		gidx = global_hist & gmask;
		guess = 1'b0;
		if (r.req_type == tbp_pkg::REQ_PREDICT) begin
			kept_local = (local_ctr[lidx] >= 2'd2);
			kept_global = (global_ctr[gidx] >= 2'd2);
			guess = (chooser_ctr[gidx] < 2'd2) ? kept_global : kept_local;
			return 1'b1;
		end
		// The chooser only moves when exactly one of the kept guesses was right.
		if (kept_local != r.outcome && kept_global == r.outcome) begin
			chooser_ctr[gidx] = sat_step(chooser_ctr[gidx], 1'b0);
		end else if (kept_local == r.outcome && kept_global != r.outcome) begin
			chooser_ctr[gidx] = sat_step(chooser_ctr[gidx], 1'b1);
		end
		local_ctr[lidx] = sat_step(local_ctr[lidx], r.outcome);
		local_hist[pidx] = {lidx[10:0], r.outcome} & lmask;
		global_ctr[gidx] = sat_step(global_ctr[gidx], r.outcome);
		global_hist = {gidx[10:0], r.outcome} & gmask;
		return 1'b0;
	endfunction

	// Offer one request, wait for it to be taken and record the expected guess.
	task automatic send_request(input branch_req_t r, input logic typed, input logic typed_guess);
		logic guess;
		while ($urandom_range(0, 99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, r.outcome, r.pc};
		s_axis_tuser <= r.req_type;
		do @(posedge clk); while (!s_axis_tready);
		if (run_tournament(r, guess)) begin
			pending_guesses.push_back(typed ? typed_guess : guess);
		end
	endtask

	// Stop sending, wait for all guesses and let a trailing train request finish.
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_guesses.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
	endtask

	// One register write; the caller lowers cfg_we after the last one.
	task automatic write_reg(input logic [tbp_pkg::CFG_INDEX_W-1:0] idx,
	                         input logic [tbp_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			tbp_pkg::CFG_GLOBAL_BITS: gbits = val;
			tbp_pkg::CFG_LOCAL_BITS:  lbits = val;
			tbp_pkg::CFG_PC_BITS:     pbits = val;
			default: ;
		endcase
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: random back-pressure and in-order comparison of guesses.
	initial begin
		logic want;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (pending_guesses.size() == 0) begin
					$error("taken_guess: expected none, actual %0d", m_axis_tdata[0]);
					errors++;
				end else begin
					want = pending_guesses.pop_front();
					if (m_axis_tdata[0] !== want) begin
						$error("taken_guess: expected %0d, actual %0d", want, m_axis_tdata[0]);
						errors++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// Main sequence: reset, directed rows, then random phases per size setting.
	initial begin
		logic [31:0] hot_pc [8];
		logic        flip [8];
		branch_req_t r;
		int          sent;
		int          k;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			local_hist[i] = '0;
			local_ctr[i] = tbp_pkg::CTR_INIT;
			global_ctr[i] = tbp_pkg::CTR_INIT;
			chooser_ctr[i] = tbp_pkg::CTR_INIT;
		end
		global_hist = '0;
		kept_local = 1'b0;
		kept_global = 1'b0;
		gbits = tbp_pkg::GLOBAL_BITS_RST;
		lbits = tbp_pkg::LOCAL_BITS_RST;
		pbits = tbp_pkg::PC_BITS_RST;
		send_idle = 15;
		recv_idle = 78;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_request(directed[i].req, directed[i].typed, directed[i].guess);
		end
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 3) begin
				send_idle = 15;
				recv_idle = 78;
			end else if (ph < 5) begin
				send_idle = 78;
				recv_idle = 15;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			// One phase takes random sizes anywhere in the register range.
			if (ph == 5) begin
				for (int j = 0; j < 3; j++) begin
					phase_cfg[ph][j] = 4'($urandom_range(0, 15));
				end
			end
			write_reg(tbp_pkg::CFG_GLOBAL_BITS, phase_cfg[ph][0]);
			write_reg(tbp_pkg::CFG_LOCAL_BITS, phase_cfg[ph][1]);
			write_reg(tbp_pkg::CFG_PC_BITS, phase_cfg[ph][2]);
			if (ph == 5) begin
				write_reg(CFG_UNUSED, 4'($urandom_range(0, 15)));
			end
			cfg_we <= 1'b0;

			for (int j = 0; j < 8; j++) begin
				hot_pc[j] = $urandom;
				flip[j] = 1'b0;
			end

			// Mostly predict-then-train pairs on a few hot branches with
			// characteristic behavior, the rest arbitrary single requests.
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 99) < 80) begin
					k = $urandom_range(0, 7);
					r.req_type = tbp_pkg::REQ_PREDICT;
					r.pc = hot_pc[k];
					r.outcome = 1'($urandom_range(0, 1));
					send_request(r, 1'b0, 1'b0);
					r.req_type = tbp_pkg::REQ_TRAIN;
					case (k % 4)
						0: r.outcome = ($urandom_range(0, 9) != 0);
						1: r.outcome = ($urandom_range(0, 9) == 0);
						2: begin
							flip[k] = ~flip[k];
							r.outcome = flip[k];
						end
						default: r.outcome = 1'($urandom_range(0, 1));
					endcase
					send_request(r, 1'b0, 1'b0);
					sent += 2;
				end else begin
					r.req_type = 1'($urandom_range(0, 1));
					r.pc = $urandom;
					r.outcome = 1'($urandom_range(0, 1));
					send_request(r, 1'b0, 1'b0);
					sent++;
				end
			end
			drain();
		end

		if (errors == 0) begin
			$display("tournament_branch_predictor_top: match");
		end else begin
			$display("tournament_branch_predictor_top: mismatch");
		end
		$finish;
	end

	// Watchdog for a stalled handshake.
	initial begin
		#5ms;
		$display("tournament_branch_predictor_top: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
